### hdl/dsu_pkg.sv
// shared types and constants for the union-find block
// payload structs for both channels and the sequencer state encoding; no dependencies
package dsu_pkg;

  localparam int IDX_W  = 10;
  localparam int SIZE_W = 10;
  localparam int CNT_W  = 10;

  typedef struct packed {
    logic [IDX_W-1:0] first_elem;
    logic [IDX_W-1:0] second_elem;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  set_count;
    logic [SIZE_W-1:0] largest_size;
    logic              bad_index;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_GROW,
    ST_DONE
  } state_t;

endpackage

### hdl/disjoint_set_union_by_size.sv
// union-find by size over elements 1..element_count, one result per input pair
// depends on dsu_pkg for the payload structs and the sequencer states
//
// Each input transaction names two elements. A small sequencer walks the parent
// links of both elements through one single-port table that holds a parent index
// and a tree size per entry, links the smaller root under the larger one (on a
// tie the first element's root goes under the second's), and then writes the new
// size of the kept root. Every input gives one output transaction with the
// current set count (element_count minus merges done, floored at zero), the size
// of the largest set and a bad_index flag for an index that is zero, above
// element_count or above MAX_ELEMENTS; a flagged item changes nothing. Each step of
// a root walk is one read of the table, which has one port with a registered read;
// a joined pair then writes the link and the new root size, and every result waits
// in ST_DONE until the output register is free. Input stall is high while an item
// is in work. After reset the table is swept once, one entry per cycle, over all
// MAX_ELEMENTS + 1 entries, during which no input is taken; the configuration port
// is always ready and element_count may be rewritten between items without
// touching any other state.
module disjoint_set_union_by_size #(
  parameter int MAX_ELEMENTS = 1023
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  dsu_pkg::in_item_t  in_item,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output dsu_pkg::out_item_t out_item,
  // configuration write: element_count
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_data
);
  import dsu_pkg::*;

  localparam int DEPTH = MAX_ELEMENTS + 1;
  localparam int AW    = $clog2(DEPTH);

  typedef struct packed {
    logic [AW-1:0]     parent;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // link table: one port, registered read
  entry_t            mem [DEPTH];
  entry_t            rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  entry_t            mem_wdata;

  // control state
  state_t            state, state_next;
  logic [AW-1:0]     clr_idx, clr_idx_next;
  logic [CNT_W-1:0]  merges_done, merges_done_next;
  logic [SIZE_W-1:0] max_set_size, max_set_size_next;
  logic [CNT_W-1:0]  element_count;
  logic              out_valid_next;

  // per-item working registers
  logic [AW-1:0]     cur, cur_next;
  logic [AW-1:0]     second_addr, second_addr_next;
  logic [AW-1:0]     root_a, root_a_next;
  logic [SIZE_W-1:0] size_a, size_a_next;
  logic [AW-1:0]     big, big_next;
  logic [SIZE_W-1:0] total, total_next;
  logic              bad, bad_next;
  out_item_t         out_item_next;

  // index checks on the incoming pair
  logic              bad_now;
  logic [SIZE_W-1:0] size_sum;
  logic [CNT_W-1:0]  sets_now;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign bad_now = (in_item.first_elem == '0) || (in_item.second_elem == '0) ||
                   (in_item.first_elem > element_count) ||
                   (in_item.second_elem > element_count) ||
                   (int'(in_item.first_elem) > MAX_ELEMENTS) ||
                   (int'(in_item.second_elem) > MAX_ELEMENTS);

  // a merged tree never holds more than 1023 elements, so ten bits suffice
  assign size_sum = size_a + rdata.size;
  assign sets_now = (element_count > merges_done) ? (element_count - merges_done) : '0;

  // table: write or read, never both in one cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else begin
      rdata <= mem[mem_addr];
    end
  end

  // sequencer: next state, table access and working values
  always_comb begin
    state_next        = state;
    clr_idx_next      = clr_idx;
    merges_done_next  = merges_done;
    max_set_size_next = max_set_size;
    cur_next          = cur;
    second_addr_next  = second_addr;
    root_a_next       = root_a;
    size_a_next       = size_a;
    big_next          = big;
    total_next        = total;
    bad_next          = bad;
    out_item_next     = out_item;
    // a waiting result leaves when the far side takes it
    out_valid_next    = out_valid && out_stall;
    mem_we            = 1'b0;
    mem_addr          = cur;
    mem_wdata         = '0;

    unique case (state)
      ST_CLEAR: begin
        // every element its own root of size one
        mem_we       = 1'b1;
        mem_addr     = clr_idx;
        mem_wdata    = '{parent: clr_idx, size: SIZE_W'(1)};
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == AW'(MAX_ELEMENTS)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_addr = AW'(in_item.first_elem);
        if (in_valid) begin
          bad_next         = bad_now;
          cur_next         = AW'(in_item.first_elem);
          second_addr_next = AW'(in_item.second_elem);
          state_next       = bad_now ? ST_DONE : ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (rdata.parent == cur) begin
          // root of the first element found, start on the second
          root_a_next = cur;
          size_a_next = rdata.size;
          cur_next    = second_addr;
          mem_addr    = second_addr;
          state_next  = ST_WALK_B;
        end else begin
          cur_next = rdata.parent;
          mem_addr = rdata.parent;
        end
      end
      ST_WALK_B: begin
        if (rdata.parent == cur) begin
          if (cur == root_a) begin
            // already in one set
            state_next = ST_DONE;
          end else begin
            // hang the smaller root under the larger, tie goes under the second
            mem_we     = 1'b1;
            total_next = size_sum;
            state_next = ST_GROW;
            if (size_a > rdata.size) begin
              big_next  = root_a;
              mem_addr  = cur;
              mem_wdata = '{parent: root_a, size: rdata.size};
            end else begin
              big_next  = cur;
              mem_addr  = root_a;
              mem_wdata = '{parent: cur, size: size_a};
            end
          end
        end else begin
          cur_next = rdata.parent;
          mem_addr = rdata.parent;
        end
      end
      ST_GROW: begin
        mem_we           = 1'b1;
        mem_addr         = big;
        mem_wdata        = '{parent: big, size: total};
        merges_done_next = merges_done + CNT_W'(1);
        if (total > max_set_size) begin
          max_set_size_next = total;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // load the result once the output register is free
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_item_next  = '{set_count: sets_now, largest_size: max_set_size,
                             bad_index: bad};
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      merges_done   <= '0;
      max_set_size  <= SIZE_W'(1);
      out_valid     <= 1'b0;
      element_count <= CNT_W'(1023);
    end else begin
      state        <= state_next;
      clr_idx      <= clr_idx_next;
      merges_done  <= merges_done_next;
      max_set_size <= max_set_size_next;
      out_valid    <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        element_count <= cfg_data;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    cur         <= cur_next;
    second_addr <= second_addr_next;
    root_a      <= root_a_next;
    size_a      <= size_a_next;
    big         <= big_next;
    total       <= total_next;
    bad         <= bad_next;
    out_item    <= out_item_next;
  end

endmodule
